@@ hw/rtl/cheat_code_line_engine_assert.svh @@
// Assertion macros for the cheat code line engine.
// Included by the RTL files that carry assertions; needs no other file.
`ifndef CHEAT_CODE_LINE_ENGINE_ASSERT_SVH
`define CHEAT_CODE_LINE_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define CCE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cheat code line engine: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define CCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cheat code line engine: assertion failed");
`else
`define CCE_ASSERT_SAME(label, clk, rst, ante, cons)
`define CCE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/cce_pkg.sv @@
// Shared types, opcodes and helper functions of the cheat code line engine.
// Used by cce_exec and cheat_code_line_engine; depends on nothing else.
package cce_pkg;

   // Opcodes in the top byte of a code word.
   localparam logic [7:0] OP_REPEAT   = 8'h50;
   localparam logic [7:0] OP_EQ_BYTE  = 8'hd0;
   localparam logic [7:0] OP_EQ_HALF  = 8'hd1;
   localparam logic [7:0] OP_NE_BYTE  = 8'hd2;
   localparam logic [7:0] OP_NE_HALF  = 8'hd3;
   localparam logic [7:0] OP_WR_BYTE  = 8'h80;
   localparam logic [7:0] OP_WR_HALF  = 8'h81;
   localparam logic [7:0] OP_BOOT_BYTE = 8'ha0;
   localparam logic [7:0] OP_BOOT_HALF = 8'ha1;

   // Memory size limits.
   localparam logic [24:0] RAM_MAX        = 25'h100_0000;
   localparam logic [24:0] RAM_SIZE_RESET = 25'h080_0000;

   // One input word.
   typedef struct packed {
      logic        kind;
      logic        entry_start;
      logic        boot_phase;
      logic [31:0] code_addr;
      logic [15:0] code_val;
      logic [15:0] mem_value;
   } item_type;

   // One result word.
   typedef struct packed {
      logic        write_valid;
      logic [23:0] write_addr;
      logic        write_half;
      logic [15:0] write_data;
      logic        write_cached;
      logic        more_pending;
   } result_type;

   // True when a byte or halfword at addr lies wholly below the limit.
   function automatic logic fits(input logic [24:0] addr, input logic half,
                                 input logic [24:0] limit);
      logic [25:0] last_end;
      last_end = {1'b0, addr} + (half ? 26'd2 : 26'd1);
      return last_end <= {1'b0, limit};
   endfunction

   // Data cut down to the access size.
   function automatic logic [15:0] size_mask(input logic [15:0] data, input logic half);
      return half ? data : {8'h00, data[7:0]};
   endfunction

   // Build a write result; an out-of-range write has its write fields cleared, more_pending is kept.
   function automatic result_type make_write(input logic [24:0] addr, input logic half,
                                             input logic [15:0] data, input logic cached,
                                             input logic more, input logic [24:0] limit);
      result_type res;
      res = '0;
      if (fits(addr, half, limit)) begin
         res.write_valid  = 1'b1;
         res.write_addr   = addr[23:0];
         res.write_half   = half;
         res.write_data   = size_mask(data, half);
         res.write_cached = cached;
      end
      res.more_pending = more;
      return res;
   endfunction

endpackage

@@ hw/rtl/cheat_code_line_engine.sv @@
// Top level of the cheat code line engine: stream ports, input and result
// registers, memory size register. Depends on cce_pkg and cce_exec.

// The engine takes one word per clock while the output is not stalled and gives
// exactly one result word for each word taken: the word waits in the input
// register, then makes a single pass through the decode logic of cce_exec into
// the result register. The skip, repeater and run state lives in cce_exec and
// is updated in that same pass, so back-to-back words see each other's effects.
// A code line (tuser 0) that writes in the current phase yields the first write
// of its run; each drain tick (tuser 1) yields the next while more_pending is set.
// Writes that would reach past the memory size are dropped, compare reads see zero.
// The memory size register may only be written while the engine is idle.
module cheat_code_line_engine (
   input  logic        clock,
   input  logic        reset,
   // Input words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // entry_start, boot_phase, code_addr, code_val, mem_value
   input  logic        req_tuser,  // kind
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // write_valid, write_addr, write_half, write_data,
                                   // write_cached, more_pending
   // Memory size register.
   input  logic        csr_wr_en,
   input  logic [24:0] csr_wr_data
);
   import cce_pkg::*;

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_item_ff;
   logic [24:0] ram_size_ff;
   logic        advance;
   logic        req_fire;
   item_type    req_item;
   result_type  exec_result;

   // Unpack the incoming word.
   assign req_item.kind        = req_tuser;
   assign req_item.entry_start = req_tdata[0];
   assign req_item.boot_phase  = req_tdata[1];
   assign req_item.code_addr   = req_tdata[33:2];
   assign req_item.code_val    = req_tdata[49:34];
   assign req_item.mem_value   = req_tdata[65:50];

   // Handshake: the held word moves on whenever the result register is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   cce_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (in_item_ff),
      .ram_size (ram_size_ff),
      .result   (exec_result)
   );

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ram_size_ff  <= RAM_SIZE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ram_size_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= exec_result;
      end
   end

   // Pack the result word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0,
                        rsp_item_ff.more_pending,
                        rsp_item_ff.write_cached,
                        rsp_item_ff.write_data,
                        rsp_item_ff.write_half,
                        rsp_item_ff.write_addr,
                        rsp_item_ff.write_valid};

endmodule

@@ hw/rtl/cce_exec.sv @@
// Execution stage of the cheat code line engine: skip, repeater and run state
// plus the single-pass decode of one word. Depends on cce_pkg and the assert header.
`include "cheat_code_line_engine_assert.svh"

module cce_exec (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  cce_pkg::item_type   item,
   input  logic [24:0]         ram_size,
   output cce_pkg::result_type result
);
   import cce_pkg::*;

   logic        skip_ff, skip_in;
   logic [7:0]  repeat_count_ff, repeat_count_in;
   logic [7:0]  addr_step_ff, addr_step_in;
   logic [15:0] value_step_ff, value_step_in;
   logic [24:0] run_addr_ff, run_addr_in;
   logic [15:0] run_value_ff, run_value_in;
   logic [7:0]  run_remaining_ff, run_remaining_in;
   logic        run_half_ff, run_half_in;
   logic        run_cached_ff, run_cached_in;

   logic [24:0] limit;
   logic [7:0]  op;
   logic [24:0] phys;
   logic        is_write;
   logic        half;
   logic        cached;
   logic        boot;
   logic [15:0] mask_val;
   logic        equal;
   logic [7:0]  count;
   logic [7:0]  drain_left;

   // Oversized memory settings act as the full address space.
   assign limit = (ram_size > RAM_MAX) ? RAM_MAX : ram_size;
   assign op    = item.code_addr[31:24];
   assign phys  = {1'b0, item.code_addr[23:0]};

   // Decode of one word against the current state.
   always_comb begin
      skip_in          = skip_ff;
      repeat_count_in  = repeat_count_ff;
      addr_step_in     = addr_step_ff;
      value_step_in    = value_step_ff;
      run_addr_in      = run_addr_ff;
      run_value_in     = run_value_ff;
      run_remaining_in = run_remaining_ff;
      run_half_in      = run_half_ff;
      run_cached_in    = run_cached_ff;
      result           = '0;
      is_write         = 1'b0;
      half             = (op == OP_EQ_HALF) || (op == OP_NE_HALF) ||
                         (op == OP_WR_HALF) || (op == OP_BOOT_HALF);
      cached           = (op == OP_WR_BYTE) || (op == OP_WR_HALF);
      boot             = (op == OP_BOOT_BYTE) || (op == OP_BOOT_HALF);
      mask_val         = size_mask(item.code_val, half);
      // A compare read beyond memory sees zero.
      equal            = ((fits(phys, half, limit) ? size_mask(item.mem_value, half)
                                                   : 16'd0) == mask_val);
      count            = (repeat_count_ff == 8'd0) ? 8'd1 : repeat_count_ff;
      drain_left       = run_remaining_ff - 8'd1;

      if (item.kind) begin
         // Drain tick: emit the next write of the run, if any.
         if (run_remaining_ff != 8'd0) begin
            run_remaining_in = drain_left;
            run_addr_in      = run_addr_ff + {17'd0, addr_step_ff};
            run_value_in     = run_value_ff + value_step_ff;
            result = make_write(run_addr_ff, run_half_ff, run_value_ff, run_cached_ff,
                                drain_left != 8'd0, limit);
         end
      end else begin
         // A code line abandons any run; an entry start clears skip and repeater.
         run_remaining_in = 8'd0;
         if (item.entry_start) begin
            skip_in         = 1'b0;
            repeat_count_in = 8'd0;
            addr_step_in    = 8'd0;
            value_step_in   = 16'd0;
         end
         count = (repeat_count_in == 8'd0) ? 8'd1 : repeat_count_in;

         if (op == OP_REPEAT) begin
            // A skipped repeater line only consumes the skip.
            if (skip_in) begin
               skip_in = 1'b0;
            end else begin
               repeat_count_in = (item.code_addr[15:8] == 8'd0) ? 8'd1
                                                                 : item.code_addr[15:8];
               addr_step_in    = item.code_addr[7:0];
               value_step_in   = item.code_val;
            end
         end else if (skip_in) begin
            skip_in         = 1'b0;
            repeat_count_in = 8'd0;
         end else begin
            repeat_count_in = 8'd0;
            case (op)
               OP_EQ_BYTE, OP_EQ_HALF: begin
                  skip_in = !equal;
               end
               OP_NE_BYTE, OP_NE_HALF: begin
                  skip_in = equal;
               end
               OP_WR_BYTE, OP_WR_HALF, OP_BOOT_BYTE, OP_BOOT_HALF: begin
                  // Only writes of the current phase start a run.
                  if (boot == item.boot_phase) begin
                     is_write         = 1'b1;
                     run_half_in      = half;
                     run_cached_in    = cached;
                     run_addr_in      = phys + {17'd0, addr_step_in};
                     run_value_in     = mask_val + value_step_in;
                     run_remaining_in = count - 8'd1;
                     result = make_write(phys, half, mask_val, cached,
                                         count != 8'd1, limit);
                  end
               end
               default: begin
                  repeat_count_in = 8'd0;
               end
            endcase
         end
      end
   end

   // State registers, updated once per processed word.
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff          <= 1'b0;
         repeat_count_ff  <= 8'd0;
         addr_step_ff     <= 8'd0;
         value_step_ff    <= 16'd0;
         run_addr_ff      <= 25'd0;
         run_value_ff     <= 16'd0;
         run_remaining_ff <= 8'd0;
         run_half_ff      <= 1'b0;
         run_cached_ff    <= 1'b0;
      end else if (fire) begin
         skip_ff          <= skip_in;
         repeat_count_ff  <= repeat_count_in;
         addr_step_ff     <= addr_step_in;
         value_step_ff    <= value_step_in;
         run_addr_ff      <= run_addr_in;
         run_value_ff     <= run_value_in;
         run_remaining_ff <= run_remaining_in;
         run_half_ff      <= run_half_in;
         run_cached_ff    <= run_cached_in;
      end
   end

   // A code line that is not a write leaves no run behind.
   `CCE_ASSERT_NEXT(a_line_ends_run, clock, reset, !reset && fire && !item.kind && !is_write, run_remaining_ff == 8'd0)
   // A drain tick on a live run takes exactly one step off it.
   `CCE_ASSERT_NEXT(a_drain_counts, clock, reset, !reset && fire && item.kind && (run_remaining_ff != 8'd0), run_remaining_ff == ($past(run_remaining_ff) - 8'd1))
   // The pending flag of a result matches the run left behind.
   `CCE_ASSERT_NEXT(a_more_matches, clock, reset, !reset && fire, $past(result.more_pending) == (run_remaining_ff != 8'd0))
   // A write that is reported lies inside memory.
   `CCE_ASSERT_SAME(a_write_in_range, clock, reset, fire && result.write_valid, fits({1'b0, result.write_addr}, result.write_half, limit))

endmodule
